>>> rtl/csp_pkg.sv
package csp_pkg;

	localparam int COORD_BITS = 16;
	// multiplier operand width: tension times a coordinate difference, or the denominator
	localparam int MW = (COORD_BITS + 10 > 27) ? COORD_BITS + 10 : 27;
	// accumulator width for the full Hermite numerator
	localparam int AW = COORD_BITS + 32;
	localparam int SAMP_W = 6;
	localparam int TEN_W = 9;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 9;
	localparam int DIV_CNT_W = $clog2(COORD_BITS);

	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TENSION = 2'd1;

	localparam logic [SAMP_W-1:0] SAMP_RESET = 6'd8;
	localparam logic [SAMP_W-1:0] SAMP_MIN = 6'd2;
	localparam logic [TEN_W-1:0] TEN_RESET = 9'd128;
	localparam logic [TEN_W-1:0] TEN_MAX = 9'd256;

	localparam logic OPC_POINT = 1'b0;
	localparam logic OPC_END = 1'b1;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_N2,
		OP_N3,
		OP_TD1,
		OP_TD2,
		OP_DP0,
		OP_S2,
		OP_S3,
		OP_S2N,
		OP_SN2,
		OP_HCALC,
		OP_ACC0,
		OP_ACC1,
		OP_ACC2,
		OP_DIVI,
		OP_DIVS
	} op_t;

	typedef struct packed {
		op_t  op;
		logic axis;
		logic accept;
		logic s_inc;
		logic load_sample;
		logic load_end;
		logic eor;
	} cmd_t;

	typedef struct packed {
		logic ps_ge2;
		logic last_s;
		logic out_free;
	} stat_t;

endpackage

>>> rtl/csp_in_if.sv
interface csp_in_if;
	logic                             valid;
	logic                             ready;
	logic                             operation;
	logic [csp_pkg::COORD_BITS-1:0]   point_x;
	logic [csp_pkg::COORD_BITS-1:0]   point_y;
	logic [15:0]                      point_value;

	modport source (output valid, operation, point_x, point_y, point_value, input ready);
	modport sink (input valid, operation, point_x, point_y, point_value, output ready);
endinterface

>>> rtl/csp_out_if.sv
interface csp_out_if;
	logic                             valid;
	logic                             ready;
	logic [csp_pkg::COORD_BITS-1:0]   curve_x;
	logic [csp_pkg::COORD_BITS-1:0]   curve_y;
	logic [15:0]                      curve_value;
	logic                             end_of_run;

	modport source (output valid, curve_x, curve_y, curve_value, end_of_run, input ready);
	modport sink (input valid, curve_x, curve_y, curve_value, end_of_run, output ready);
endinterface

>>> rtl/csp_cfg_if.sv
interface csp_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [csp_pkg::CFG_IDX_W-1:0]    index;
	logic [csp_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/cardinal_spline_sampler.sv
// Cardinal spline sampler.
// in_ch  : control points (operation 0) or end of path (operation 1); a transfer
//          is valid && ready. ready is high whenever the block is idle.
// out_ch : curve samples, valid/ready; end_of_run marks the last result of an item.
// cfg_ch : register writes (index 0 samples per segment, index 1 tension), always
//          ready; write only while idle.
// From the third point of a path on, each point produces one segment of N samples.
// An end item after two or more points produces the final segment plus the last point with its value.
// Each sample runs five basis steps, then per axis three multiply-accumulate
// steps, a divider setup and a restoring divider (one quotient bit per cycle),
// and then loads the output register. Segment setup first computes N squared,
// N cubed and, per axis, the two tension terms and the base term; a segment
// item holds the input until its last result is loaded. An end item adds the
// endpoint result after its final segment.
// An item that produces no result leaves the block idle.
// A full output register stalls the sequencer until the receiver takes it;
// the next input is taken as soon as the last result is loaded.
// Reset: window and point count cleared, samples 8, tension 128, no output valid.
module cardinal_spline_sampler (
	input  logic        clk,
	input  logic        arst_n,
	csp_in_if.sink      in_ch,
	csp_out_if.source   out_ch,
	csp_cfg_if.sink     cfg_ch
);

	csp_pkg::cmd_t   cmd;
	csp_pkg::stat_t  stat;
	logic            ctrl_ready;

	// sequencer: segment setup, per-sample steps, divider count, emit
	csp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_op    (in_ch.operation),
		.in_ready (ctrl_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// window, multiplier, divider and output register
	csp_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch),
		.cmd    (cmd),
		.stat   (stat)
	);

	// input ready comes straight from the sequencer
	assign in_ch.ready = ctrl_ready;

	// a point that opens no segment leaves the block idle
	a_short_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && in_ch.operation == csp_pkg::OPC_POINT && !stat.ps_ge2)
		|=> ctrl_ready)
		else $error("idle not restored after point without segment");

	// while a non-final result waits, no new input transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.end_of_run) |-> !in_ch.ready)
		else $error("input ready while results remain");

	// a transfer is always a load by the sequencer
	a_ready_match: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready == ctrl_ready)
		else $error("input ready mismatch");

endmodule

>>> rtl/csp_ctrl.sv
module csp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_op,
	output logic            in_ready,
	input  csp_pkg::stat_t  stat,
	output csp_pkg::cmd_t   cmd
);

	typedef enum logic [1:0] {IDLE, RUN, EMIT_S, EMIT_END} state_t;

	state_t                          state_q;
	csp_pkg::op_t                    op_q;
	logic                            axis_q;
	logic                            endflag_q;
	logic [csp_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic                            accept;

	assign in_ready = (state_q == IDLE);
	assign accept = in_ready && in_valid;

	always_comb begin
		cmd = '0;
		cmd.op = (state_q == RUN) ? op_q : csp_pkg::OP_NONE;
		cmd.axis = axis_q;
		cmd.accept = accept;
		cmd.load_sample = (state_q == EMIT_S) && stat.out_free;
		cmd.s_inc = cmd.load_sample && !stat.last_s;
		cmd.eor = stat.last_s && !endflag_q;
		cmd.load_end = (state_q == EMIT_END) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			op_q <= csp_pkg::OP_NONE;
			axis_q <= 1'b0;
			endflag_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (accept && stat.ps_ge2) begin
						state_q <= RUN;
						op_q <= csp_pkg::OP_N2;
						axis_q <= 1'b0;
						endflag_q <= (in_op == csp_pkg::OPC_END);
					end
				end
				RUN: begin
					case (op_q)
						csp_pkg::OP_N2:   op_q <= csp_pkg::OP_N3;
						csp_pkg::OP_N3:   op_q <= csp_pkg::OP_TD1;
						csp_pkg::OP_TD1:  op_q <= csp_pkg::OP_TD2;
						csp_pkg::OP_TD2:  op_q <= csp_pkg::OP_DP0;
						csp_pkg::OP_DP0: begin
							if (!axis_q) begin
								axis_q <= 1'b1;
								op_q <= csp_pkg::OP_TD1;
							end else begin
								axis_q <= 1'b0;
								op_q <= csp_pkg::OP_S2;
							end
						end
						csp_pkg::OP_S2:    op_q <= csp_pkg::OP_S3;
						csp_pkg::OP_S3:    op_q <= csp_pkg::OP_S2N;
						csp_pkg::OP_S2N:   op_q <= csp_pkg::OP_SN2;
						csp_pkg::OP_SN2:   op_q <= csp_pkg::OP_HCALC;
						csp_pkg::OP_HCALC: op_q <= csp_pkg::OP_ACC0;
						csp_pkg::OP_ACC0:  op_q <= csp_pkg::OP_ACC1;
						csp_pkg::OP_ACC1:  op_q <= csp_pkg::OP_ACC2;
						csp_pkg::OP_ACC2: begin
							op_q <= csp_pkg::OP_DIVI;
							cnt_q <= '0;
						end
						csp_pkg::OP_DIVI:  op_q <= csp_pkg::OP_DIVS;
						csp_pkg::OP_DIVS: begin
							if (cnt_q == csp_pkg::DIV_CNT_W'(csp_pkg::COORD_BITS - 1)) begin
								if (!axis_q) begin
									axis_q <= 1'b1;
									op_q <= csp_pkg::OP_ACC0;
								end else begin
									state_q <= EMIT_S;
									op_q <= csp_pkg::OP_NONE;
								end
							end else begin
								cnt_q <= cnt_q + 1'b1;
							end
						end
						default: state_q <= IDLE;
					endcase
				end
				EMIT_S: begin
					if (stat.out_free) begin
						if (stat.last_s) begin
							state_q <= endflag_q ? EMIT_END : IDLE;
						end else begin
							state_q <= RUN;
							op_q <= csp_pkg::OP_S2;
							axis_q <= 1'b0;
						end
					end
				end
				EMIT_END: begin
					if (stat.out_free) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

>>> rtl/csp_datapath.sv
module csp_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	csp_in_if.sink               in_ch,
	csp_out_if.source            out_ch,
	csp_cfg_if.sink              cfg_ch,
	input  csp_pkg::cmd_t        cmd,
	output csp_pkg::stat_t       stat
);

	localparam int CW = csp_pkg::COORD_BITS;
	localparam int MW = csp_pkg::MW;
	localparam int AW = csp_pkg::AW;
	localparam int SW = csp_pkg::SAMP_W;
	localparam int TW = csp_pkg::TEN_W;

	// configuration registers
	logic [SW-1:0]  samp_cfg_q;
	logic [TW-1:0]  ten_cfg_q;

	// path window, x is axis 0 and y is axis 1
	logic [CW-1:0]  win_q [2][3];
	logic [15:0]    newest_q;
	logic [1:0]     ps_q;

	// segment operands: pm1, p0, p1, p2
	logic [CW-1:0]  p_q [2][4];
	logic [15:0]    endval_q;
	logic [SW-1:0]  n_q;
	logic [TW-1:0]  ten_q;
	logic [SW-1:0]  s_q;

	logic signed [MW-1:0] n2_q, n3_q, s2_q, s3_q, s2n_q, sn2_q;
	logic signed [MW-1:0] h01_q, h10_q, h11_q;
	logic signed [MW-1:0] td1_q [2];
	logic signed [MW-1:0] td2_q [2];
	logic signed [AW-1:0] base_q [2];
	logic signed [AW-1:0] acc_q;

	// divider
	logic signed [AW-1:0] rem_q, dvs_q;
	logic [CW-1:0]        quo_q;
	logic                 neg_q, sat_q;
	logic [CW-1:0]        div_res;
	logic [CW-1:0]        resx_q;

	logic                 out_valid_q;
	logic [CW-1:0]        out_x_q, out_y_q;
	logic [15:0]          out_val_q;
	logic                 out_eor_q;

	logic signed [MW-1:0]   mul_a, mul_b, n_w, s_w, ten_w, den_w;
	logic signed [CW:0]     d1, d2, d10;
	logic signed [2*MW-1:0] prod;
	logic signed [AW-1:0]   prod_a, den_a, rnd, lim;
	logic                   ax;
	logic [1:0]             old_sel;

	assign ax = cmd.axis;
	assign n_w = MW'(n_q);
	assign s_w = MW'(s_q);
	assign ten_w = MW'(ten_q);
	assign den_w = n3_q <<< 8;
	assign d1 = $signed({1'b0, p_q[ax][2]}) - $signed({1'b0, p_q[ax][0]});
	assign d2 = $signed({1'b0, p_q[ax][3]}) - $signed({1'b0, p_q[ax][1]});
	assign d10 = $signed({1'b0, p_q[ax][2]}) - $signed({1'b0, p_q[ax][1]});

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			csp_pkg::OP_N2:   begin mul_a = n_w;    mul_b = n_w;    end
			csp_pkg::OP_N3:   begin mul_a = n2_q;   mul_b = n_w;    end
			csp_pkg::OP_TD1:  begin mul_a = ten_w;  mul_b = MW'(d1); end
			csp_pkg::OP_TD2:  begin mul_a = ten_w;  mul_b = MW'(d2); end
			csp_pkg::OP_DP0:  begin mul_a = den_w;  mul_b = MW'(p_q[ax][1]); end
			csp_pkg::OP_S2:   begin mul_a = s_w;    mul_b = s_w;    end
			csp_pkg::OP_S3:   begin mul_a = s2_q;   mul_b = s_w;    end
			csp_pkg::OP_S2N:  begin mul_a = s2_q;   mul_b = n_w;    end
			csp_pkg::OP_SN2:  begin mul_a = s_w;    mul_b = n2_q;   end
			csp_pkg::OP_ACC0: begin mul_a = h01_q;  mul_b = MW'(d10) <<< 8; end
			csp_pkg::OP_ACC1: begin mul_a = h10_q;  mul_b = td1_q[ax]; end
			csp_pkg::OP_ACC2: begin mul_a = h11_q;  mul_b = td2_q[ax]; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign prod = (2*MW)'(mul_a) * (2*MW)'(mul_b);
	assign prod_a = $signed(prod[AW-1:0]);
	assign den_a = AW'(n3_q) <<< 8;
	assign rnd = acc_q + (AW'(n3_q) <<< 7);
	assign lim = den_a <<< CW;
	assign div_res = neg_q ? '0 : (sat_q ? '1 : quo_q);

	assign old_sel = (ps_q == 2'd3) ? 2'd0 : 2'd1;

	assign stat.ps_ge2 = ps_q[1];
	assign stat.last_s = (s_q == n_q - 1'b1);
	assign stat.out_free = !out_valid_q || out_ch.ready;

	assign cfg_ch.ready = 1'b1;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samp_cfg_q <= csp_pkg::SAMP_RESET;
			ten_cfg_q <= csp_pkg::TEN_RESET;
		end else if (cfg_ch.valid) begin
			if (cfg_ch.index == csp_pkg::CFG_SAMPLES) begin
				samp_cfg_q <= cfg_ch.data[SW-1:0];
			end else if (cfg_ch.index == csp_pkg::CFG_TENSION) begin
				ten_cfg_q <= cfg_ch.data[TW-1:0];
			end
		end
	end

	// window and point count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 2; a++) begin
				for (int i = 0; i < 3; i++) begin
					win_q[a][i] <= '0;
				end
			end
			newest_q <= '0;
			ps_q <= '0;
		end else if (cmd.accept) begin
			if (in_ch.operation == csp_pkg::OPC_POINT) begin
				for (int a = 0; a < 2; a++) begin
					win_q[a][0] <= win_q[a][1];
					win_q[a][1] <= win_q[a][2];
				end
				win_q[0][2] <= in_ch.point_x;
				win_q[1][2] <= in_ch.point_y;
				newest_q <= in_ch.point_value;
				if (ps_q != 2'd3) begin
					ps_q <= ps_q + 2'd1;
				end
			end else begin
				for (int a = 0; a < 2; a++) begin
					for (int i = 0; i < 3; i++) begin
						win_q[a][i] <= '0;
					end
				end
				newest_q <= '0;
				ps_q <= '0;
			end
		end
	end

	// segment latch and arithmetic sequence
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			for (int a = 0; a < 2; a++) begin
				p_q[a][0] <= win_q[a][old_sel];
				p_q[a][1] <= win_q[a][1];
				p_q[a][2] <= win_q[a][2];
				p_q[a][3] <= win_q[a][2];
			end
			if (in_ch.operation == csp_pkg::OPC_POINT) begin
				p_q[0][3] <= in_ch.point_x;
				p_q[1][3] <= in_ch.point_y;
			end
			endval_q <= newest_q;
			n_q <= (samp_cfg_q < csp_pkg::SAMP_MIN) ? csp_pkg::SAMP_MIN : samp_cfg_q;
			ten_q <= (ten_cfg_q > csp_pkg::TEN_MAX) ? csp_pkg::TEN_MAX : ten_cfg_q;
			s_q <= '0;
		end else if (cmd.s_inc) begin
			s_q <= s_q + 1'b1;
		end

		case (cmd.op)
			csp_pkg::OP_N2:   n2_q <= prod[MW-1:0];
			csp_pkg::OP_N3:   n3_q <= prod[MW-1:0];
			csp_pkg::OP_TD1:  td1_q[ax] <= prod[MW-1:0];
			csp_pkg::OP_TD2:  td2_q[ax] <= prod[MW-1:0];
			csp_pkg::OP_DP0:  base_q[ax] <= prod_a;
			csp_pkg::OP_S2:   s2_q <= prod[MW-1:0];
			csp_pkg::OP_S3:   s3_q <= prod[MW-1:0];
			csp_pkg::OP_S2N:  s2n_q <= prod[MW-1:0];
			csp_pkg::OP_SN2:  sn2_q <= prod[MW-1:0];
			csp_pkg::OP_HCALC: begin
				h01_q <= MW'(3 * s2n_q - 2 * s3_q);
				h10_q <= MW'(s3_q - 2 * s2n_q + sn2_q);
				h11_q <= s3_q - s2n_q;
			end
			csp_pkg::OP_ACC0: begin
				acc_q <= base_q[ax] + prod_a;
				// x result is final once the y pass starts
				if (ax) begin
					resx_q <= div_res;
				end
			end
			csp_pkg::OP_ACC1: acc_q <= acc_q + prod_a;
			csp_pkg::OP_ACC2: acc_q <= acc_q + prod_a;
			csp_pkg::OP_DIVI: begin
				neg_q <= rnd[AW-1];
				sat_q <= (rnd >= lim);
				rem_q <= rnd;
				dvs_q <= den_a <<< (CW - 1);
				quo_q <= '0;
			end
			csp_pkg::OP_DIVS: begin
				if (rem_q >= dvs_q) begin
					rem_q <= rem_q - dvs_q;
					quo_q <= {quo_q[CW-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[CW-2:0], 1'b0};
				end
				dvs_q <= dvs_q >>> 1;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_sample || cmd.load_end) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_sample) begin
			out_x_q <= resx_q;
			out_y_q <= div_res;
			out_val_q <= '0;
			out_eor_q <= cmd.eor;
		end else if (cmd.load_end) begin
			out_x_q <= p_q[0][2];
			out_y_q <= p_q[1][2];
			out_val_q <= endval_q;
			out_eor_q <= 1'b1;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.curve_x = out_x_q;
	assign out_ch.curve_y = out_y_q;
	assign out_ch.curve_value = out_val_q;
	assign out_ch.end_of_run = out_eor_q;

endmodule

>>> tb/sv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = csp_pkg::COORD_BITS;

	// Longest stretch with no transfer on any channel before the run is declared hung.
	// Worst case: a sample behind a long receiver hold-off, plus segment setup.
	localparam int WATCHDOG_LIMIT = 40000;
	// Cycles to let pass once nothing is expected (no-result items leave the block idle).
	localparam int SETTLE_CYCLES = 20;

	// indexes past the two registers, written to check they are ignored
	localparam logic [csp_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [csp_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	typedef struct {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [15:0]   value;
		logic          eor;
	} curve_sample_t;

	logic clk;
	logic arst_n;

	csp_in_if  in_ch ();
	csp_out_if out_ch ();
	csp_cfg_if cfg_ch ();

	cardinal_spline_sampler dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	// ------------------------------------------------------------------
	// Predictor state: shadow registers and the three-point window
	// ------------------------------------------------------------------
	logic [csp_pkg::SAMP_W-1:0] shadow_samples;
	logic [csp_pkg::TEN_W-1:0]  shadow_tension;
	logic [CW-1:0]              win_x [3];
	logic [CW-1:0]              win_y [3];
	logic [15:0]                last_value;
	int                         path_points;

	curve_sample_t expected_samples [$];

	int error_count;
	int tx_idle_pct;
	int rx_idle_pct;
	int rx_hold_cycles;
	int stall_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Hermite sample: num / (256*N^3), rounded half up, clamped to 0..max
	// ------------------------------------------------------------------
	function automatic logic [CW-1:0] hermite_coord(longint pm1, longint p0,
			longint p1, longint p2, longint s, longint n, longint ten);
		longint s2, s3, n2, n3, h00, h10, h01, h11, num, den, acc, q;
		s2  = s * s;
		s3  = s2 * s;
		n2  = n * n;
		n3  = n2 * n;
		h00 = 2 * s3 - 3 * s2 * n + n3;
		h10 = s3 - 2 * s2 * n + s * n2;
		h01 = -2 * s3 + 3 * s2 * n;
		h11 = s3 - s2 * n;
		num = 256 * (h00 * p0 + h01 * p1) + ten * (h10 * (p1 - pm1) + h11 * (p2 - p0));
		den = 256 * n3;
		acc = num + den / 2;
		if (acc < 0)
			return '0;
		q = acc / den;
		if (q > (longint'(1) << CW) - 1)
			q = (longint'(1) << CW) - 1;
		return q[CW-1:0];
	endfunction

	// Append one expected result at the tail of the queue.
	task automatic queue_expected(curve_sample_t smp);
		expected_samples.insert(expected_samples.size(), smp);
	endtask

	// Queue the samples of one segment; slot 0 is the previous neighbor, 3 the next one.
	task automatic queue_segment(logic [CW-1:0] sx [4], logic [CW-1:0] sy [4]);
		longint n, ten;
		curve_sample_t smp;
		n   = (shadow_samples < csp_pkg::SAMP_MIN) ? csp_pkg::SAMP_MIN : shadow_samples;
		ten = (shadow_tension > csp_pkg::TEN_MAX) ? csp_pkg::TEN_MAX : shadow_tension;
		for (longint s = 0; s < n; s++) begin
			smp.x     = hermite_coord(sx[0], sx[1], sx[2], sx[3], s, n, ten);
			smp.y     = hermite_coord(sy[0], sy[1], sy[2], sy[3], s, n, ten);
			smp.value = '0;
			smp.eor   = 1'b0;
			queue_expected(smp);
		end
	endtask

	// Advance the predictor by one accepted input transfer.
	task automatic predict_curve(logic op, logic [CW-1:0] x, logic [CW-1:0] y,
			logic [15:0] value);
		logic [CW-1:0] sx [4];
		logic [CW-1:0] sy [4];
		int before_cnt;
		int prev;
		curve_sample_t smp;
		before_cnt = expected_samples.size();
		prev = (path_points >= 3) ? 0 : 1;   // clamp the left neighbor at the path start
		sx[0] = win_x[prev]; sy[0] = win_y[prev];
		sx[1] = win_x[1];    sy[1] = win_y[1];
		sx[2] = win_x[2];    sy[2] = win_y[2];
		if (op == csp_pkg::OPC_POINT) begin
			sx[3] = x;
			sy[3] = y;
			if (path_points >= 2)
				queue_segment(sx, sy);
			win_x[0] = win_x[1]; win_y[0] = win_y[1];
			win_x[1] = win_x[2]; win_y[1] = win_y[2];
			win_x[2] = x;        win_y[2] = y;
			last_value = value;
			if (path_points < 3)
				path_points++;
		end else begin
			if (path_points >= 2) begin
				// right neighbor clamped: the last point repeated
				sx[3] = win_x[2];
				sy[3] = win_y[2];
				queue_segment(sx, sy);
				smp.x     = win_x[2];
				smp.y     = win_y[2];
				smp.value = last_value;
				smp.eor   = 1'b0;
				queue_expected(smp);
			end
			for (int i = 0; i < 3; i++) begin
				win_x[i] = '0;
				win_y[i] = '0;
			end
			last_value  = '0;
			path_points = 0;
		end
		if (expected_samples.size() > before_cnt)
			expected_samples[expected_samples.size() - 1].eor = 1'b1;
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		error_count++;
	endtask

	// ------------------------------------------------------------------
	// Result checker. Everything is driven at posedge, so the values seen at
	// negedge are exactly what the next rising edge will transfer.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		curve_sample_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_samples.size() == 0) begin
				report_mismatch("unexpected result x", out_ch.curve_x, 0);
			end else begin
				want = expected_samples.pop_front();
				if (out_ch.curve_x !== want.x)
					report_mismatch("curve_x", out_ch.curve_x, want.x);
				if (out_ch.curve_y !== want.y)
					report_mismatch("curve_y", out_ch.curve_y, want.y);
				if (out_ch.curve_value !== want.value)
					report_mismatch("curve_value", out_ch.curve_value, want.value);
				if (out_ch.end_of_run !== want.eor)
					report_mismatch("end_of_run", out_ch.end_of_run, want.eor);
			end
		end
	end

	// Receiver: random stalls, or a counted hold-off when one is requested.
	always @(posedge clk) begin
		if (rx_hold_cycles > 0) begin
			out_ch.ready <= 1'b0;
			rx_hold_cycles <= rx_hold_cycles - 1;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Watchdog: cycles in a row with no transfer anywhere
	always @(negedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// One input transfer. valid is left high on return so back-to-back items
	// stream without a bubble; gaps and park_input lower it.
	task automatic send_item(logic op, logic [CW-1:0] x, logic [CW-1:0] y,
			logic [15:0] value);
		logic rdy;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.operation   <= op;
		in_ch.point_x     <= x;
		in_ch.point_y     <= y;
		in_ch.point_value <= value;
		do begin
			@(negedge clk);
			rdy = in_ch.ready;
			@(posedge clk);
		end while (!rdy);
		predict_curve(op, x, y, value);
	endtask

	task automatic park_input();
		in_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Sender pause: wait for every expected result, then for the block to settle.
	task automatic wait_drained();
		park_input();
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write; only called with the block drained.
	task automatic write_reg(logic [csp_pkg::CFG_IDX_W-1:0] index,
			logic [csp_pkg::CFG_DATA_W-1:0] data);
		logic rdy;
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data  <= data;
		do begin
			@(negedge clk);
			rdy = cfg_ch.ready;
			@(posedge clk);
		end while (!rdy);
		cfg_ch.valid <= 1'b0;
		if (index == csp_pkg::CFG_SAMPLES)
			shadow_samples = data[csp_pkg::SAMP_W-1:0];
		else if (index == csp_pkg::CFG_TENSION)
			shadow_tension = data[csp_pkg::TEN_W-1:0];
		@(posedge clk);
	endtask

	function automatic logic [CW-1:0] rand_coord();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return CW'($urandom());
		endcase
	endfunction

	task automatic send_point();
		send_item(csp_pkg::OPC_POINT, rand_coord(), rand_coord(), 16'($urandom()));
	endtask

	// A path: mostly well-formed runs of points closed by an end item; a few are
	// short (no results) or just stray end items.
	task automatic send_path(int max_pts);
		int npts;
		npts = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(max_pts, 2);
		repeat (npts) send_point();
		// occasionally leave the path open; the next path simply continues it
		if ($urandom_range(9) != 0)
			send_item(csp_pkg::OPC_END, CW'($urandom()), CW'($urandom()), 16'($urandom()));
	endtask

	// Random settings that favor small sample counts; upper data bits are
	// random because only the low six bits land in the register.
	task automatic random_config(int max_samples);
		logic [csp_pkg::CFG_DATA_W-1:0] d;
		d = csp_pkg::CFG_DATA_W'($urandom());
		d[csp_pkg::SAMP_W-1:0] = csp_pkg::SAMP_W'($urandom_range(max_samples));
		write_reg(csp_pkg::CFG_SAMPLES, d);
		write_reg(csp_pkg::CFG_TENSION, csp_pkg::CFG_DATA_W'($urandom()));
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset defaults, short paths, extremes, both register extremes and
	// out-of-range writes.
	task automatic test_directed();
		// reset settings: samples 8, tension 128
		send_item(csp_pkg::OPC_END, '0, '0, '0);                  // end with nothing stored
		send_item(csp_pkg::OPC_POINT, 16'h1234, 16'hFEDC, 16'hAAAA);
		send_item(csp_pkg::OPC_END, '0, '0, '0);                  // end with one point
		send_item(csp_pkg::OPC_POINT, '0, '1, 16'hFFFF);
		send_item(csp_pkg::OPC_POINT, '1, '0, 16'h0001);
		send_item(csp_pkg::OPC_END, '1, '1, '1);                  // end with two points
		wait_drained();
		write_reg(csp_pkg::CFG_SAMPLES, 9'd2);
		write_reg(csp_pkg::CFG_TENSION, 9'd0);
		send_item(csp_pkg::OPC_POINT, '0, '0, '0);
		send_item(csp_pkg::OPC_POINT, '1, '1, '1);
		send_item(csp_pkg::OPC_POINT, '0, '0, 16'h5555);
		send_item(csp_pkg::OPC_END, '0, '0, '0);
		wait_drained();
		// strongest tension, finest sampling: overshoot drives clamping
		write_reg(csp_pkg::CFG_SAMPLES, 9'd63);
		write_reg(csp_pkg::CFG_TENSION, 9'd256);
		send_item(csp_pkg::OPC_POINT, '0, '1, '0);
		send_item(csp_pkg::OPC_POINT, '1, '0, '1);
		send_item(csp_pkg::OPC_POINT, '0, '1, 16'h8000);
		send_item(csp_pkg::OPC_POINT, '1, '0, 16'h7FFF);
		send_item(csp_pkg::OPC_END, '0, '0, '0);
		wait_drained();
		// tension above one acts as one; sample count below two acts as two;
		// indexes past the two registers are ignored
		write_reg(csp_pkg::CFG_TENSION, 9'h1FF);
		write_reg(csp_pkg::CFG_SAMPLES, 9'h1C0);
		write_reg(CFG_SPARE_LO, 9'h155);
		write_reg(CFG_SPARE_HI, 9'h0AA);
		send_item(csp_pkg::OPC_POINT, 16'h0100, '1, 16'h0F0F);
		send_item(csp_pkg::OPC_POINT, '1, 16'h0100, 16'hF0F0);
		send_item(csp_pkg::OPC_POINT, '0, '0, 16'h00FF);
		send_item(csp_pkg::OPC_END, '0, '0, '0);
		wait_drained();
		write_reg(csp_pkg::CFG_SAMPLES, 9'd1);
		send_item(csp_pkg::OPC_POINT, 16'h8000, 16'h8000, '1);
		send_item(csp_pkg::OPC_POINT, 16'h7FFF, 16'h8001, '0);
		send_item(csp_pkg::OPC_END, '0, '0, '0);
		wait_drained();
	endtask

	// Random traffic in one idling pattern, with fresh settings every few paths.
	task automatic test_random_phase(int tx_pct, int rx_pct, int n_paths);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int p = 0; p < n_paths; p++) begin
			if (p % 6 == 0) begin
				wait_drained();
				random_config(8);
			end
			send_path(7);
		end
		wait_drained();
	endtask

	// A few items at the largest sample count with zero tension.
	task automatic test_large_segments();
		tx_idle_pct = 10;
		rx_idle_pct = 10;
		write_reg(csp_pkg::CFG_SAMPLES, 9'd63);
		write_reg(csp_pkg::CFG_TENSION, 9'd0);
		repeat (3) send_point();
		send_item(csp_pkg::OPC_END, '0, '0, '0);
		wait_drained();
	endtask

	// Receiver holds off for a long stretch while points keep coming, so the
	// output register fills and the input stalls behind it.
	task automatic test_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_reg(csp_pkg::CFG_SAMPLES, 9'd4);
		write_reg(csp_pkg::CFG_TENSION, 9'd200);
		rx_hold_cycles = 1500;
		repeat (10) send_point();
		send_item(csp_pkg::OPC_END, '0, '0, '0);
		wait_drained();
	endtask

	initial begin
		arst_n            = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.operation   = csp_pkg::OPC_POINT;
		in_ch.point_x     = '0;
		in_ch.point_y     = '0;
		in_ch.point_value = '0;
		out_ch.ready      = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = '0;
		cfg_ch.data       = '0;
		error_count       = 0;
		stall_cycles      = 0;
		rx_hold_cycles    = 0;
		tx_idle_pct       = 0;
		rx_idle_pct       = 0;
		shadow_samples    = csp_pkg::SAMP_RESET;
		shadow_tension    = csp_pkg::TEN_RESET;
		for (int i = 0; i < 3; i++) begin
			win_x[i] = '0;
			win_y[i] = '0;
		end
		last_value  = '0;
		path_points = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_phase(32, 50, 18);
		test_random_phase(50, 32, 18);
		test_random_phase(0, 0, 18);
		test_large_segments();
		test_backpressure();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
